FILE: rtl/core/bpfs_pkg.sv
// Shared constants for the back-EMF PLL flying-start block: sizes, phase,
// status and register codes, and the CORDIC arctangent table.
// No dependencies.
package bpfs_pkg;

   localparam int TIMEOUT_LIMIT = 2000;
   localparam int LOCK_LIMIT    = 500;
   localparam int CORDIC_STEPS  = 16;
   localparam int CSTEP_W       = $clog2(CORDIC_STEPS);

   localparam int TICK_W        = 12;
   localparam int LOCK_W        = 10;
   localparam int LOCK_ERR      = 1043;
   localparam int INV_SQRT3_Q16 = 37837;

   localparam int VOLT_W     = 16;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 72;
   localparam int STATUS_W   = 3;
   localparam int RPM_W      = 20;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_TRACK = 2'd1;
   localparam logic [1:0] PH_SEED  = 2'd2;
   localparam logic [1:0] PH_DONE  = 2'd3;

   localparam logic [STATUS_W-1:0] STAT_TRACKING = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_COAST    = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_TIMEOUT  = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_HANDOFF  = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_FINISHED = 3'd4;

   localparam logic [CSR_IDX_W-1:0] REG_PROP_GAIN     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INTEGRAL_GAIN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SAMPLE_PERIOD = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RPM_SCALE     = 2'd3;

   // atan(2^-i) in 2^-32 turns
   function automatic logic [31:0] atan_turn(input logic [4:0] idx);
      logic [31:0] t;
      unique case (idx)
         5'd0:    t = 32'd536870912;
         5'd1:    t = 32'd316933406;
         5'd2:    t = 32'd167458907;
         5'd3:    t = 32'd85004756;
         5'd4:    t = 32'd42667331;
         5'd5:    t = 32'd21354465;
         5'd6:    t = 32'd10679838;
         5'd7:    t = 32'd5340245;
         5'd8:    t = 32'd2670163;
         5'd9:    t = 32'd1335087;
         5'd10:   t = 32'd667544;
         5'd11:   t = 32'd333772;
         5'd12:   t = 32'd166886;
         5'd13:   t = 32'd83443;
         5'd14:   t = 32'd41722;
         5'd15:   t = 32'd20861;
         5'd16:   t = 32'd10430;
         5'd17:   t = 32'd5215;
         5'd18:   t = 32'd2608;
         5'd19:   t = 32'd1304;
         5'd20:   t = 32'd652;
         5'd21:   t = 32'd326;
         5'd22:   t = 32'd163;
         5'd23:   t = 32'd81;
         default: t = 32'd0;
      endcase
      return t;
   endfunction

endpackage

FILE: rtl/core/bemf_pll_flying_start.sv
// Back-EMF PLL flying start: Clarke transform, CORDIC angle, PI loop, lock/timeout sequencing.
// One shared 33x33 multiplier and one CORDIC shift-add stage under a sequencer.
// Depends on bpfs_pkg.
//
// Channel   Direction  Handshake               Contents
// req       in         req_tvalid/req_tready   tuser operation; tdata volt_u, volt_v, volt_w
// rsp       out        rsp_tvalid/rsp_tready   tuser status; tdata angle_out, speed_out, rpm_out
// csr       in         csr_valid/csr_ready     csr_index register, csr_data value
//
// A tracking tick runs the CORDIC iterations and the chain of products through the single
// multiplier before the block is ready for the next item.
// A zero-vector tick skips the CORDIC and the loop update.
// Synchronous active-high reset loads register defaults and clears the estimator.
// A stalled result waits in the output register; the next item is taken meanwhile.
module bemf_pll_flying_start (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [bpfs_pkg::REQ_DATA_W-1:0]     req_tdata,  // volt_u, volt_v, volt_w
   input  logic                                req_tuser,  // operation
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [bpfs_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // angle_out, speed_out, rpm_out, pad
   output logic [bpfs_pkg::STATUS_W-1:0]       rsp_tuser,  // status
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bpfs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bpfs_pkg::CSR_DATA_W-1:0]     csr_data
);
   import bpfs_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_BETA   = 4'd1;
   localparam logic [3:0] S_KD     = 4'd2;
   localparam logic [3:0] S_CORDIC = 4'd3;
   localparam logic [3:0] S_ERR    = 4'd4;
   localparam logic [3:0] S_MUL_LO = 4'd5;
   localparam logic [3:0] S_MUL_HI = 4'd6;
   localparam logic [3:0] S_ISUM   = 4'd7;
   localparam logic [3:0] S_IADD   = 4'd8;
   localparam logic [3:0] S_SPEED  = 4'd9;
   localparam logic [3:0] S_AMUL   = 4'd10;
   localparam logic [3:0] S_ANGLE  = 4'd11;
   localparam logic [3:0] S_FIN    = 4'd12;
   localparam logic [3:0] S_RMUL   = 4'd13;
   localparam logic [3:0] S_RPM    = 4'd14;
   localparam logic [3:0] S_OUT    = 4'd15;

   localparam logic [LOCK_W-1:0] LOCK_MAX = {LOCK_W{1'b1}};
   localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

   function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
      logic signed [31:0] r;
      if (v > 42'sd2147483647)       r = 32'sh7FFF_FFFF;
      else if (v < -42'sd2147483648) r = 32'sh8000_0000;
      else                           r = v[31:0];
      return r;
   endfunction

   // control and state
   logic [3:0]             state_ff, state_in;
   logic [1:0]             phase_ff, phase_in;
   logic [TICK_W-1:0]      tick_ff, tick_in;
   logic [LOCK_W-1:0]      lock_ff, lock_in;
   logic [15:0]            angle_ff, angle_in;
   logic signed [31:0]     speed_ff, speed_in;
   logic signed [31:0]     integ_ff, integ_in;
   logic [23:0]            prop_gain_ff;
   logic [31:0]            int_gain_ff;
   logic [31:0]            period_ff;
   logic [21:0]            rpm_scale_ff;
   logic                   rsp_valid_ff, rsp_valid_in;

   // datapath
   logic [CSTEP_W-1:0]     cnt_ff, cnt_in;
   logic signed [29:0]     x_ff, x_in, y_ff, y_in;
   logic [31:0]            acc_ff, acc_in;
   logic signed [16:0]     alpha_ff, alpha_in;
   logic signed [17:0]     s3_ff, s3_in;
   logic [63:0]            prod_ff, prod_in;
   logic [47:0]            kd_ff, kd_in;
   logic [63:0]            lo_ff, lo_in;
   logic [63:0]            sum_ff, sum_in;
   logic [15:0]            emag_ff, emag_in;
   logic                   eneg_ff, eneg_in;
   logic signed [32:0]     pterm_ff, pterm_in;
   logic                   timeout_ff, timeout_in;
   logic [STATUS_W-1:0]    res_status_ff, res_status_in;
   logic [RPM_W-1:0]       res_rpm_ff, res_rpm_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;

   // shared multiplier
   logic                   mul_en;
   logic signed [32:0]     mul_a, mul_b;
   logic signed [65:0]     mul_full;

   // intermediates
   logic signed [15:0]     vu, vv, vw;
   logic [12:0]            tick_next;
   logic [63:0]            beta_t;
   logic signed [18:0]     beta;
   logic signed [29:0]     xs, ys;
   logic [31:0]            atan_val;
   logic [31:0]            obs_t;
   logic [15:0]            err;
   logic signed [41:0]     isum;
   logic [40:0]            pround;
   logic [32:0]            pmag;
   logic signed [41:0]     ssum;
   logic [31:0]            spd_mag;
   logic [63:0]            rnd_t;
   logic [15:0]            ang_step;
   logic [21:0]            rpm_mag;

   assign mul_full   = mul_a * mul_b;
   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

   assign vu = $signed(req_tdata[15:0]);
   assign vv = $signed(req_tdata[31:16]);
   assign vw = $signed(req_tdata[47:32]);

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      tick_in       = tick_ff;
      lock_in       = lock_ff;
      angle_in      = angle_ff;
      speed_in      = speed_ff;
      integ_in      = integ_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      cnt_in        = cnt_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      acc_in        = acc_ff;
      alpha_in      = alpha_ff;
      s3_in         = s3_ff;
      kd_in         = kd_ff;
      lo_in         = lo_ff;
      sum_in        = sum_ff;
      emag_in       = emag_ff;
      eneg_in       = eneg_ff;
      pterm_in      = pterm_ff;
      timeout_in    = timeout_ff;
      res_status_in = res_status_ff;
      res_rpm_in    = res_rpm_ff;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      mul_en        = 1'b0;
      mul_a         = '0;
      mul_b         = '0;

      tick_next = {1'b0, tick_ff} + 13'd1;
      beta_t    = prod_ff + 64'd32768;
      beta      = $signed(beta_t[34:16]);
      xs        = x_ff >>> cnt_ff;
      ys        = y_ff >>> cnt_ff;
      atan_val  = atan_turn(5'(cnt_ff));
      obs_t     = acc_ff + 32'h0000_8000;
      err       = obs_t[31:16] - angle_ff;
      isum      = {{10{integ_ff[31]}}, integ_ff} +
                  (eneg_ff ? -$signed({2'b00, sum_ff[63:24]}) : $signed({2'b00, sum_ff[63:24]}));
      pround    = {1'b0, prod_ff[39:0]} + 41'd128;
      pmag      = pround[40:8];
      ssum      = {{9{pterm_ff[32]}}, pterm_ff} + {{10{integ_ff[31]}}, integ_ff};
      spd_mag   = speed_ff[31] ? (32'd0 - speed_ff) : speed_ff;
      rnd_t     = prod_ff + 64'h0000_0000_8000_0000;
      ang_step  = rnd_t[47:32];
      rpm_mag   = rnd_t[53:32];
      prod_in   = mul_en ? mul_full[63:0] : prod_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               res_rpm_in    = '0;
               res_status_in = STAT_TRACKING;
               if (!req_tuser) begin
                  phase_in = PH_IDLE;
                  state_in = S_OUT;
               end else begin
                  unique case (phase_ff)
                     PH_IDLE: begin
                        tick_in       = '0;
                        lock_in       = '0;
                        angle_in      = '0;
                        speed_in      = '0;
                        integ_in      = '0;
                        phase_in      = PH_TRACK;
                        res_status_in = STAT_COAST;
                        state_in      = S_OUT;
                     end
                     PH_TRACK: begin
                        tick_in    = (tick_next > {1'b0, TICK_MAX}) ? TICK_MAX
                                                                    : tick_next[TICK_W-1:0];
                        timeout_in = (tick_next > 13'(TIMEOUT_LIMIT));
                        alpha_in   = 17'(vu) - 17'(vw);
                        s3_in      = 18'(vu) - (18'(vv) <<< 1) + 18'(vw);
                        state_in   = S_BETA;
                     end
                     PH_SEED: state_in = S_RMUL;
                     PH_DONE: begin
                        res_status_in = STAT_FINISHED;
                        state_in      = S_OUT;
                     end
                     default: state_in = S_OUT;
                  endcase
               end
            end
         end
         S_BETA: begin
            mul_en   = 1'b1;
            mul_a    = 33'(s3_ff);
            mul_b    = 33'(INV_SQRT3_Q16);
            state_in = S_KD;
         end
         S_KD: begin
            mul_en = 1'b1;
            mul_a  = $signed({1'b0, int_gain_ff});
            mul_b  = $signed({1'b0, period_ff});
            cnt_in = '0;
            if (beta < 0) begin
               x_in   = -{{3{beta[18]}}, beta, 8'd0};
               y_in   = {{5{alpha_ff[16]}}, alpha_ff, 8'd0};
               acc_in = 32'h8000_0000;
            end else begin
               x_in   = {{3{beta[18]}}, beta, 8'd0};
               y_in   = -{{5{alpha_ff[16]}}, alpha_ff, 8'd0};
               acc_in = '0;
            end
            state_in = (alpha_ff == '0 && beta == '0) ? S_FIN : S_CORDIC;
         end
         S_CORDIC: begin
            if (!y_ff[29]) begin
               x_in   = x_ff + ys;
               y_in   = y_ff - xs;
               acc_in = acc_ff + atan_val;
            end else begin
               x_in   = x_ff - ys;
               y_in   = y_ff + xs;
               acc_in = acc_ff - atan_val;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CSTEP_W'(CORDIC_STEPS - 1)) state_in = S_ERR;
         end
         S_ERR: begin
            kd_in   = prod_ff[63:16];
            eneg_in = err[15];
            emag_in = err[15] ? (16'd0 - err) : err;
            if ((err[15] ? (16'd0 - err) : err) < 16'(LOCK_ERR))
               lock_in = (lock_ff == LOCK_MAX) ? lock_ff : lock_ff + 1'b1;
            else
               lock_in = '0;
            state_in = S_MUL_LO;
         end
         S_MUL_LO: begin
            mul_en   = 1'b1;
            mul_a    = $signed({17'd0, emag_ff});
            mul_b    = $signed({1'b0, kd_ff[31:0]});
            state_in = S_MUL_HI;
         end
         S_MUL_HI: begin
            lo_in    = prod_ff;
            mul_en   = 1'b1;
            mul_a    = $signed({17'd0, emag_ff});
            mul_b    = $signed({17'd0, kd_ff[47:32]});
            state_in = S_ISUM;
         end
         S_ISUM: begin
            sum_in   = lo_ff + {prod_ff[31:0], 32'd0} + 64'd8388608;
            mul_en   = 1'b1;
            mul_a    = $signed({17'd0, emag_ff});
            mul_b    = $signed({9'd0, prop_gain_ff});
            state_in = S_IADD;
         end
         S_IADD: begin
            integ_in = sat32(isum);
            pterm_in = eneg_ff ? -$signed(pmag) : $signed(pmag);
            state_in = S_SPEED;
         end
         S_SPEED: begin
            speed_in = sat32(ssum);
            state_in = S_AMUL;
         end
         S_AMUL: begin
            mul_en   = 1'b1;
            mul_a    = $signed({1'b0, spd_mag});
            mul_b    = $signed({1'b0, period_ff});
            state_in = S_ANGLE;
         end
         S_ANGLE: begin
            angle_in = speed_ff[31] ? (angle_ff - ang_step) : (angle_ff + ang_step);
            state_in = S_FIN;
         end
         S_FIN: begin
            priority if (timeout_ff) begin
               phase_in      = PH_DONE;
               res_status_in = STAT_TIMEOUT;
            end else if (lock_ff >= LOCK_W'(LOCK_LIMIT)) begin
               phase_in = PH_SEED;
            end
            state_in = S_OUT;
         end
         S_RMUL: begin
            mul_en   = 1'b1;
            mul_a    = $signed({1'b0, spd_mag});
            mul_b    = $signed({11'd0, rpm_scale_ff});
            state_in = S_RPM;
         end
         S_RPM: begin
            if (!speed_ff[31])
               res_rpm_in = (rpm_mag > 22'd524287) ? 20'h7FFFF : rpm_mag[RPM_W-1:0];
            else
               res_rpm_in = (rpm_mag > 22'd524288) ? 20'h80000 : 20'(22'd0 - rpm_mag);
            phase_in      = PH_DONE;
            res_status_in = STAT_HANDOFF;
            state_in      = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_data_in   = {4'd0, res_rpm_ff, speed_ff, angle_ff};
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      prod_in = mul_en ? mul_full[63:0] : prod_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_IDLE;
         tick_ff      <= '0;
         lock_ff      <= '0;
         angle_ff     <= '0;
         speed_ff     <= '0;
         integ_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         prop_gain_ff <= 24'd2560;
         int_gain_ff  <= 32'd25600000;
         period_ff    <= 32'd214748;
         rpm_scale_ff <= 22'd983040;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         tick_ff      <= tick_in;
         lock_ff      <= lock_in;
         angle_ff     <= angle_in;
         speed_ff     <= speed_in;
         integ_ff     <= integ_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            unique case (csr_index)
               REG_PROP_GAIN:     prop_gain_ff <= csr_data[23:0];
               REG_INTEGRAL_GAIN: int_gain_ff  <= csr_data;
               REG_SAMPLE_PERIOD: period_ff    <= csr_data;
               REG_RPM_SCALE:     rpm_scale_ff <= csr_data[21:0];
               default:           ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      acc_ff        <= acc_in;
      alpha_ff      <= alpha_in;
      s3_ff         <= s3_in;
      prod_ff       <= prod_in;
      kd_ff         <= kd_in;
      lo_ff         <= lo_in;
      sum_ff        <= sum_in;
      emag_ff       <= emag_in;
      eneg_ff       <= eneg_in;
      pterm_ff      <= pterm_in;
      timeout_ff    <= timeout_in;
      res_status_ff <= res_status_in;
      res_rpm_ff    <= res_rpm_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

endmodule

FILE: rtl/core/bpfs_checker.sv
// Port-level checks for bemf_pll_flying_start, attached by bind.
// Depends on bpfs_pkg and the top level's port list.
module bpfs_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [bpfs_pkg::REQ_DATA_W-1:0]     req_tdata,  // volt_u, volt_v, volt_w
   input logic                                req_tuser,  // operation
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [bpfs_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // angle_out, speed_out, rpm_out, pad
   input logic [bpfs_pkg::STATUS_W-1:0]       rsp_tuser,  // status
   input logic                                csr_valid,
   input logic                                csr_ready,
   input logic [bpfs_pkg::CSR_IDX_W-1:0]      csr_index,
   input logic [bpfs_pkg::CSR_DATA_W-1:0]     csr_data
);
   import bpfs_pkg::*;

   // an accepted item occupies the sequencer, so req_tready is low once it has been taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req_tready high right after an accepted item");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // coast request follows a fresh estimator
   a_coast_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STAT_COAST |-> rsp_tdata[67:0] == '0)
      else $error("coast request with nonzero estimate");

   a_rpm_only_handoff: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STAT_HANDOFF |-> rsp_tdata[67:48] == '0)
      else $error("rpm reported outside hand-off");

endmodule

bind bemf_pll_flying_start bpfs_checker u_bpfs_checker (.*);

FILE: test/bemf_pll_flying_start_test.sv
// Self-checking bench for bemf_pll_flying_start: a model of the phase-locked tracker predicts
// every result from the accepted items, and results are compared in order, field by field.
// Depends on bpfs_pkg and the block's RTL.
module bemf_pll_flying_start_test;
   import bpfs_pkg::*;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [15:0]         angle;
      logic [31:0]         speed;
      logic [RPM_W-1:0]    rpm;
   } pll_result_type;

   class pll_tracker_model_type;
      logic [23:0] kp_reg;
      logic [31:0] ki_reg;
      logic [31:0] period_reg;
      logic [21:0] rpm_factor;
      logic [1:0]  phase;
      int          ticks;
      int          locked_ticks;
      logic [15:0] theta;
      longint      omega;
      longint      omega_int;
      pll_result_type pending_estimates[$];
      int          mismatches;
      int          checked;
      logic [31:0] atan_lut [24];

      function new();
         atan_lut = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
                      32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
                      32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
                      32'd166886, 32'd83443, 32'd41722, 32'd20861,
                      32'd10430, 32'd5215, 32'd2608, 32'd1304,
                      32'd652, 32'd326, 32'd163, 32'd81};
         kp_reg = 24'd2560;
         ki_reg = 32'd25600000;
         period_reg = 32'd214748;
         rpm_factor = 22'd983040;
         phase = PH_IDLE;
         ticks = 0;
         locked_ticks = 0;
         theta = '0;
         omega = 0;
         omega_int = 0;
         mismatches = 0;
         checked = 0;
      endfunction

      function longint clamp32(longint s);
         if (s > 64'sd2147483647) return 64'sd2147483647;
         if (s < -64'sd2147483648) return -64'sd2147483648;
         return s;
      endfunction

      // sign(s) * round(|s| * k / 2^sh), ties away from zero
      function longint scaled_round(longint s, logic [63:0] k, int sh);
         logic [127:0] mag;
         logic [127:0] prod;
         mag = (s < 0) ? 128'(-s) : 128'(s);
         prod = (mag * {64'd0, k} + (128'd1 << (sh - 1))) >> sh;
         return (s < 0) ? -longint'({1'b0, prod[62:0]}) : longint'({1'b0, prod[62:0]});
      endfunction

      function logic [15:0] vector_angle(longint y, longint x);
         logic [31:0] acc;
         longint xs;
         longint ys;
         acc = '0;
         if (x < 0) begin
            x = -x;
            y = -y;
            acc = 32'h8000_0000;
         end
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
               x = x + ys;
               y = y - xs;
               acc = acc + atan_lut[i];
            end else begin
               x = x - ys;
               y = y + xs;
               acc = acc - atan_lut[i];
            end
         end
         acc = acc + 32'h0000_8000;
         return acc[31:16];
      endfunction

      function void advance_pll(longint u, longint v, longint w);
         longint      alpha;
         longint      beta;
         longint      err;
         longint      kd;
         longint      stride;
         logic [15:0] obs;
         logic [15:0] diff;
         alpha = u - w;
         beta = ((u - 2 * v + w) * INV_SQRT3_Q16 + 32768) >>> 16;
         if (alpha == 0 && beta == 0) return;
         obs = vector_angle(-alpha * 256, beta * 256);
         diff = obs - theta;
         err = longint'($signed(diff));
         if (err < LOCK_ERR && err > -LOCK_ERR) begin
            if (locked_ticks < 1023) locked_ticks++;
         end else begin
            locked_ticks = 0;
         end
         kd = longint'((64'(ki_reg) * 64'(period_reg)) >> 16);
         omega_int = clamp32(omega_int + scaled_round(err, kd, 24));
         omega = clamp32(scaled_round(err, 64'(kp_reg), 8) + omega_int);
         stride = scaled_round(omega, 64'(period_reg), 32);
         theta = theta + stride[15:0];
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] value);
         case (idx)
            REG_PROP_GAIN:     kp_reg = value[23:0];
            REG_INTEGRAL_GAIN: ki_reg = value;
            REG_SAMPLE_PERIOD: period_reg = value;
            REG_RPM_SCALE:     rpm_factor = value[21:0];
            default: ;
         endcase
      endfunction

      function void predict_item(logic op, logic [15:0] u, logic [15:0] v, logic [15:0] w);
         pll_result_type res;
         longint      rpm;
         int          next_ticks;
         res.status = STAT_TRACKING;
         rpm = 0;
         if (!op) begin
            phase = PH_IDLE;
         end else if (phase == PH_IDLE) begin
            ticks = 0;
            locked_ticks = 0;
            theta = '0;
            omega = 0;
            omega_int = 0;
            phase = PH_TRACK;
            res.status = STAT_COAST;
         end else if (phase == PH_TRACK) begin
            next_ticks = ticks + 1;
            ticks = (next_ticks > 4095) ? 4095 : next_ticks;
            advance_pll(longint'($signed(u)), longint'($signed(v)), longint'($signed(w)));
            if (next_ticks > TIMEOUT_LIMIT) begin
               phase = PH_DONE;
               res.status = STAT_TIMEOUT;
            end else if (locked_ticks >= LOCK_LIMIT) begin
               phase = PH_SEED;
            end
         end else if (phase == PH_SEED) begin
            rpm = scaled_round(omega, 64'(rpm_factor), 32);
            if (rpm > 524287) rpm = 524287;
            if (rpm < -524288) rpm = -524288;
            phase = PH_DONE;
            res.status = STAT_HANDOFF;
         end else begin
            res.status = STAT_FINISHED;
         end
         res.angle = theta;
         res.speed = omega[31:0];
         res.rpm = rpm[RPM_W-1:0];
         pending_estimates.push_back(res);
      endfunction

      function void check_result(logic [STATUS_W-1:0] status, logic [15:0] angle,
                                 logic [31:0] speed, logic [RPM_W-1:0] rpm);
         pll_result_type want;
         checked++;
         if (pending_estimates.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: status %0d angle %0d speed %0d rpm %0d",
                        status, angle, $signed(speed), $signed(rpm));
            return;
         end
         want = pending_estimates.pop_front();
         if (want.status !== status || want.angle !== angle || want.speed !== speed ||
             want.rpm !== rpm) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result %0d: expected status %0d angle %0d speed %0d rpm %0d, %s%0d %0d %0d %0d",
                        checked, want.status, want.angle, $signed(want.speed),
                        $signed(want.rpm), "got ", status, angle, $signed(speed),
                        $signed(rpm));
         end
      endfunction

      function int pending();
         return pending_estimates.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   pll_tracker_model_type tracker = new();
   int req_quiet = 0;

   bemf_pll_flying_start i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("bemf_pll_flying_start verification failed");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) tracker.write_reg(csr_index, csr_data);
         if (req_tvalid && req_tready)
            tracker.predict_item(req_tuser, req_tdata[15:0], req_tdata[31:16],
                                 req_tdata[47:32]);
         if (rsp_tvalid && rsp_tready)
            tracker.check_result(rsp_tuser, rsp_tdata[15:0], rsp_tdata[47:16],
                                 rsp_tdata[67:48]);
      end
   end

   function automatic int draw_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic logic [15:0] field_value();
      case ($urandom_range(0, 19))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'hFFFF;
         4: return 16'h0001;
         default: return 16'($urandom);
      endcase
   endfunction

   // receiver: random stalls, quiet stretches, and one long hold-off
   initial begin : rsp_side
      int stall_left;
      int quiet;
      bit held;
      stall_left = 0;
      quiet = 0;
      held = 1'b0;
      rsp_tready = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (!held && tracker.checked >= 150) begin
            rsp_tready <= 1'b0;
            repeat (600) @(negedge clock);
            held = 1'b1;
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            if (quiet > 0) begin
               quiet--;
            end else begin
               stall_left = draw_gap();
               if ($urandom_range(0, 99) == 0) quiet = 60;
            end
         end
      end
   end

   // entered and left at a falling edge; valid stays up for a back-to-back item
   task automatic send_item(input logic op, input logic [15:0] u, input logic [15:0] v,
                            input logic [15:0] w);
      int gap;
      if (req_quiet > 0) begin
         req_quiet--;
         gap = 0;
      end else begin
         gap = draw_gap();
         if ($urandom_range(0, 99) == 0) req_quiet = 60;
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {w, v, u};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic send_random(input logic op);
      logic [15:0] u;
      logic [15:0] v;
      logic [15:0] w;
      u = field_value();
      v = field_value();
      w = field_value();
      if ($urandom_range(0, 9) == 0) begin
         v = u;
         w = u;
      end
      send_item(op, u, v, w);
   endtask

   // three-phase set whose observed vector angle is phi
   task automatic send_rotating(input int phi, input int amp);
      real ang;
      int  u_i;
      int  v_i;
      int  w_i;
      ang = -6.283185307179586 * phi / 65536.0 - 1.0471975511965976;
      u_i = $rtoi(amp * $cos(ang)) + int'($urandom_range(0, 4)) - 2;
      v_i = $rtoi(amp * $cos(ang - 2.0943951023931953)) + int'($urandom_range(0, 4)) - 2;
      w_i = $rtoi(amp * $cos(ang + 2.0943951023931953)) + int'($urandom_range(0, 4)) - 2;
      send_item(1'b1, u_i[15:0], v_i[15:0], w_i[15:0]);
   endtask

   // restart, coast, track until hand-off or timeout; restart aborts an overlong run
   task automatic pll_run(input int stride, input int amp, input int cap, input bit rotating);
      int phi;
      int n;
      phi = $urandom_range(0, 65535);
      n = 0;
      send_random(1'b0);
      send_random(1'b1);
      while (tracker.phase != PH_DONE && n < cap) begin
         if (rotating) send_rotating(phi, amp);
         else send_random(1'b1);
         phi = (phi + stride) & 32'hFFFF;
         n++;
      end
      if (tracker.phase == PH_DONE) repeat (3) send_random(1'b1);
      send_random(1'b0);
   endtask

   task automatic noise_items(input int count);
      repeat (count) send_random(($urandom_range(0, 99) < 8) ? 1'b0 : 1'b1);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (tracker.pending() > 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic apply_loop_setup(input logic [31:0] kp, input logic [31:0] ki,
                                   input logic [31:0] period, input logic [31:0] rpm_scale);
      write_register(REG_PROP_GAIN, kp);
      write_register(REG_INTEGRAL_GAIN, ki);
      write_register(REG_SAMPLE_PERIOD, period);
      write_register(REG_RPM_SCALE, rpm_scale);
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: coast, extremes, zero vectors, single-LSB vectors, restarts
      send_item(1'b1, 16'h0000, 16'h0000, 16'h0000);
      send_item(1'b1, 16'h7FFF, 16'h8000, 16'h7FFF);
      send_item(1'b1, 16'h8000, 16'h7FFF, 16'h8000);
      send_item(1'b1, 16'h7FFF, 16'h7FFF, 16'h8000);
      send_item(1'b1, 16'h8000, 16'h8000, 16'h7FFF);
      send_item(1'b1, 16'h0000, 16'h0000, 16'h0000);
      send_item(1'b1, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_item(1'b1, 16'h8000, 16'h8000, 16'h8000);
      send_item(1'b1, 16'h0001, 16'h0000, 16'h0000);
      send_item(1'b1, 16'h0000, 16'h0000, 16'h0001);
      send_item(1'b1, 16'h0000, 16'h0001, 16'h0000);
      send_item(1'b1, 16'hFFFF, 16'h0000, 16'h0000);
      send_item(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_item(1'b1, 16'h5555, 16'hAAAA, 16'h5555);
      send_item(1'b1, 16'hAAAA, 16'h5555, 16'hAAAA);
      send_item(1'b0, 16'h0000, 16'h0000, 16'h0000);
      send_item(1'b0, 16'h1234, 16'h5678, 16'h9ABC);
      send_item(1'b1, 16'd100, 16'd200, 16'd300);
      send_item(1'b1, 16'd300, 16'd200, 16'd100);

      // well-damped loop, slow rotation: reaches lock and hand-off
      drain();
      apply_loop_setup(32'd1024000, 32'd1024000000, 32'd214748, 32'd491520);
      pll_run(int'($urandom_range(0, 600)) - 300, $urandom_range(3000, 30000), 600, 1'b1);

      // short period, fast rotation: hand-off with rpm at its limit
      drain();
      apply_loop_setup(32'd8388608, 32'hFFFF_FFFF, 32'd65536, 32'd3932160);
      pll_run($urandom_range(0, 1) ? 10000 : -10000, 20000, 600, 1'b1);

      // zero period: frozen angle, no integration
      drain();
      apply_loop_setup(32'hFFFF_FFFF, 32'd12345678, 32'd0, 32'd1);
      noise_items(100);

      drain();
      apply_loop_setup(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      noise_items(100);

      drain();
      apply_loop_setup(32'd0, 32'd0, 32'd1, 32'd1);
      noise_items(80);

      drain();
      apply_loop_setup($urandom, $urandom, $urandom_range(1, 32'hFFFF_FFFF),
                       $urandom_range(1, 3932160));
      noise_items(80);

      drain();
      if (tracker.mismatches == 0 && tracker.pending() == 0)
         $display("bemf_pll_flying_start verification clean");
      else
         $display("bemf_pll_flying_start verification failed");
      $finish;
   end

endmodule
